/* sv/ppr_pkg.sv */
// Package: shared constants, beat types and control/status bundles for the pulse peak rate detector.
`timescale 1ns / 1ps

package ppr_pkg;

   // Window and peak store sizing
   localparam int WINDOW_LEN  = 128;
   localparam int MAX_PEAKS   = 20;
   localparam int SAMPLE_BITS = 10;

   localparam int POS_W  = $clog2(WINDOW_LEN);
   localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
   localparam int CFG_W  = 10;
   localparam int BPM_W  = 23;
   localparam int NUM_W  = BPM_W;
   localparam int DEN_W  = POS_W + CFG_W;
   localparam int ITER_W = $clog2(NUM_W + 1);

   // 60 s * 1000 ms * 100
   localparam logic [NUM_W-1:0] RATE_NUMERATOR = NUM_W'(6000000);

   localparam logic [CFG_W-1:0] BASELINE_RESET = CFG_W'(205);
   localparam logic [CFG_W-1:0] PERIOD_RESET   = CFG_W'(20);

   // CSR indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_BASELINE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD_MS = 1'd1;

   // Result kinds
   localparam logic KIND_PEAK = 1'b0;
   localparam logic KIND_RATE = 1'b1;

   // Divider operand selects
   localparam logic DIV_SEL_INTERVAL = 1'b0;
   localparam logic DIV_SEL_BPM      = 1'b1;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   window_end;
   } ppr_req_type;

   typedef struct packed {
      logic             kind;
      logic [POS_W-1:0] peak_index;
      logic [BPM_W-1:0] bpm_x100;
      logic             rate_valid;
      logic             last;
   } ppr_rsp_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic div_sel;
      logic mul_load;
      logic bpm_load;
      logic rate_emit;
   } ppr_cmd_type;

   typedef struct packed {
      logic out_free;
      logic end_now;
      logic cnt_ok;
      logic denom_nz;
      logic div_done;
   } ppr_stat_type;

endpackage

/* sv/ppr_div.sv */
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ppr_div
   import ppr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  dvs_ff, dvs_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         iter_in = ITER_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // borrow out of the trial subtract means the bit is zero
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         iter_in = iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/ppr_dp.sv */
// Datapath: config registers, peak tracking, rate arithmetic and the result register.
`timescale 1ns / 1ps

module ppr_dp
   import ppr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  ppr_req_type          req_data,
   input  ppr_cmd_type          cmd,
   output ppr_stat_type         stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ppr_rsp_type          rsp_data
);

   logic [CFG_W-1:0] base_ff, base_in;
   logic [CFG_W-1:0] period_ff, period_in;

   logic [POS_W-1:0]       spos_ff, spos_in;
   logic                   open_ff, open_in;
   logic [POS_W-1:0]       cpos_ff, cpos_in;
   logic [SAMPLE_BITS-1:0] level_ff, level_in;
   logic [POS_W-1:0]       first_ff, first_in;
   logic [POS_W-1:0]       latest_ff, latest_in;
   logic [CNT_W-1:0]       peaks_ff, peaks_in;

   logic [POS_W-1:0] diff_ff, diff_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] denom_ff, denom_in;
   logic [BPM_W-1:0] bpm_ff, bpm_in;
   logic             rvalid_ff, rvalid_in;

   logic        out_valid_ff, out_valid_in;
   ppr_rsp_type out_ff, out_in;

   logic             above, below, upd, open_any, end_now, close, record;
   logic [POS_W-1:0] pos_upd, first_new, latest_new;
   logic [CNT_W-1:0] peaks_new;

   logic [NUM_W-1:0] div_dividend, div_quotient;
   logic [DEN_W-1:0] div_divisor;
   logic             div_done;

   // peak tracking for the beat on the input
   always_comb begin
      above      = req_data.sample > base_ff;
      below      = req_data.sample < base_ff;
      upd        = above && (!open_ff || (level_ff <= req_data.sample));
      pos_upd    = upd ? spos_ff : cpos_ff;
      open_any   = open_ff || above;
      end_now    = req_data.window_end || (spos_ff == POS_W'(WINDOW_LEN - 1));
      close      = open_any && (below || end_now);
      record     = close && (peaks_ff < CNT_W'(MAX_PEAKS));
      peaks_new  = record ? peaks_ff + 1'b1 : peaks_ff;
      first_new  = (record && (peaks_ff == '0)) ? pos_upd : first_ff;
      latest_new = record ? pos_upd : latest_ff;
   end

   always_comb begin
      base_in   = base_ff;
      period_in = period_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PEAK_BASELINE:    base_in   = csr_wdata;
            CSR_SAMPLE_PERIOD_MS: period_in = csr_wdata;
            default:              ;
         endcase
      end
   end

   always_comb begin
      spos_in      = spos_ff;
      open_in      = open_ff;
      cpos_in      = cpos_ff;
      level_in     = level_ff;
      first_in     = first_ff;
      latest_in    = latest_ff;
      peaks_in     = peaks_ff;
      diff_in      = diff_ff;
      cnt_in       = cnt_ff;
      denom_in     = denom_ff;
      bpm_in       = bpm_ff;
      rvalid_in    = rvalid_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (cmd.accept) begin
         if (end_now) begin
            spos_in   = '0;
            open_in   = 1'b0;
            cpos_in   = '0;
            level_in  = '0;
            first_in  = '0;
            latest_in = '0;
            peaks_in  = '0;
            diff_in   = latest_new - first_new;
            cnt_in    = peaks_new;
            bpm_in    = '0;
            rvalid_in = 1'b0;
         end else begin
            spos_in   = spos_ff + 1'b1;
            open_in   = upd ? 1'b1 : (close ? 1'b0 : open_ff);
            cpos_in   = close ? '0 : pos_upd;
            level_in  = close ? '0 : (upd ? req_data.sample : level_ff);
            first_in  = first_new;
            latest_in = latest_new;
            peaks_in  = peaks_new;
         end
         if (close) begin
            out_in.kind       = KIND_PEAK;
            out_in.peak_index = pos_upd;
            out_in.bpm_x100   = '0;
            out_in.rate_valid = 1'b0;
            out_in.last       = !end_now;
            out_valid_in      = 1'b1;
         end
      end

      if (cmd.mul_load) begin
         denom_in = DEN_W'(div_quotient[POS_W-1:0]) * DEN_W'(period_ff);
      end
      if (cmd.bpm_load) begin
         bpm_in    = div_quotient;
         rvalid_in = 1'b1;
      end
      if (cmd.rate_emit) begin
         out_in.kind       = KIND_RATE;
         out_in.peak_index = '0;
         out_in.bpm_x100   = bpm_ff;
         out_in.rate_valid = rvalid_ff;
         out_in.last       = 1'b1;
         out_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASELINE_RESET;
         period_ff    <= PERIOD_RESET;
         spos_ff      <= '0;
         open_ff      <= 1'b0;
         cpos_ff      <= '0;
         level_ff     <= '0;
         first_ff     <= '0;
         latest_ff    <= '0;
         peaks_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         period_ff    <= period_in;
         spos_ff      <= spos_in;
         open_ff      <= open_in;
         cpos_ff      <= cpos_in;
         level_ff     <= level_in;
         first_ff     <= first_in;
         latest_ff    <= latest_in;
         peaks_ff     <= peaks_in;
         out_valid_ff <= out_valid_in;
      end
      diff_ff   <= diff_in;
      cnt_ff    <= cnt_in;
      denom_ff  <= denom_in;
      bpm_ff    <= bpm_in;
      rvalid_ff <= rvalid_in;
      out_ff    <= out_in;
   end

   // shared divider: mean interval first, then the rate
   always_comb begin
      if (cmd.div_sel == DIV_SEL_BPM) begin
         div_dividend = RATE_NUMERATOR;
         div_divisor  = denom_ff;
      end else begin
         div_dividend = NUM_W'(diff_ff);
         div_divisor  = DEN_W'(cnt_ff - 1'b1);
      end
   end

   ppr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      stat.out_free = !out_valid_ff || rsp_ready;
      stat.end_now  = end_now;
      stat.cnt_ok   = cnt_ff >= CNT_W'(2);
      stat.denom_nz = denom_ff != '0;
      stat.div_done = div_done;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* sv/ppr_ctrl.sv */
// Controller: input handshake and the window-end rate sequence.
`timescale 1ns / 1ps

module ppr_ctrl
   import ppr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ppr_stat_type stat,
   output ppr_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_IVL   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_BPM   = 3'd4;
   localparam logic [2:0] ST_RATE  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.accept = 1'b1;
               if (stat.end_now) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (stat.cnt_ok) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_INTERVAL;
               state_in      = ST_IVL;
            end else begin
               state_in = ST_RATE;
            end
         end
         ST_IVL: begin
            if (stat.div_done) begin
               cmd.mul_load = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            if (stat.denom_nz) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_BPM;
               state_in      = ST_BPM;
            end else begin
               state_in = ST_RATE;
            end
         end
         ST_BPM: begin
            cmd.div_sel = DIV_SEL_BPM;
            if (stat.div_done) begin
               cmd.bpm_load = 1'b1;
               state_in     = ST_RATE;
            end
         end
         ST_RATE: begin
            if (stat.out_free) begin
               cmd.rate_emit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/pulse_peak_rate_detector.sv */
// Top level: pulse peak and heart rate detector over a window of sensor samples.
`timescale 1ns / 1ps

// Takes one 10-bit pulse-sensor sample per req beat. Samples above the
// peak_baseline register open a peak candidate that follows the largest
// level (a later equal sample wins); a sample below the baseline closes it
// and a peak beat (kind 0, peak_index) goes out. The window ends on a beat
// with window_end set or on the 128th sample; any open peak is closed, then
// a rate beat (kind 1) carries bpm_x100 = 6000000 / (mean interval *
// sample_period_ms), with rate_valid low and bpm_x100 zero when fewer than
// two peaks were seen or the product is zero. Only the first 20 peaks enter
// the rate; later ones are still reported. The last flag marks the final
// beat caused by a sample. Timing: an ordinary sample is taken and the next
// can follow right behind it, as long as the single result register is
// empty or draining. A window-end sample drops req_ready through the check
// step; with two or more peaks, two passes of the shared bit-serial divider
// (23 quotient bits each) with the multiply step between them follow, the
// rate divide being skipped when sample_period_ms is zero; with fewer than
// two peaks both passes are skipped. The rate step ends it, after any wait
// for rsp_ready. CSR writes take effect on the next cycle and belong only
// in idle periods.

module pulse_peak_rate_detector
   import ppr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ppr_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ppr_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   ppr_cmd_type  cmd;
   ppr_stat_type stat;

   // sequencing: accept, divider runs, rate beat
   ppr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // peak tracking, arithmetic and the output register
   ppr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/tb_pulse_peak_rate_detector.sv */
// Testbench for pulse_peak_rate_detector: random windows checked against a beat scoreboard.
`timescale 1ns / 1ps

// Flow: reset, a short directed run over the corner cases, then eight config
// phases of shaped random windows (pulse trains around the baseline, a few
// windows running to the 128-sample overrun, some pure noise). Each accepted
// req beat is fed to the scoreboard, which predicts the peak and rate beats
// it causes. Each accepted rsp beat is checked against the oldest
// prediction. Both channels insert random idle gaps, with some stretches
// at full rate. A watchdog ends the run if no beat moves for too long.

module tb_pulse_peak_rate_detector;
   import ppr_pkg::*;

   localparam int IDLE_LIMIT = 3000;  // cycles without any beat before giving up
   localparam int SETTLE     = 64;    // covers the window-end divide passes
   localparam int NUM_PHASES = 8;
   localparam int PHASE_LEN  = 85;    // req beats per random phase

   // Scoreboard: mirrors the detector state and queues expected rsp beats.
   class pulse_scoreboard;
      logic [CFG_W-1:0]       baseline;
      logic [CFG_W-1:0]       period;
      logic [POS_W-1:0]       pos;
      logic                   cand_open;
      logic [POS_W-1:0]       cand_pos;
      logic [SAMPLE_BITS-1:0] cand_level;
      logic [POS_W-1:0]       first_pos;
      logic [POS_W-1:0]       latest_pos;
      logic [CNT_W-1:0]       peaks;
      ppr_rsp_type            pending[$];
      int                     mismatches;

      function new();
         baseline   = BASELINE_RESET;
         period     = PERIOD_RESET;
         mismatches = 0;
         clear_window();
      endfunction

      function void clear_window();
         pos        = '0;
         cand_open  = 1'b0;
         cand_pos   = '0;
         cand_level = '0;
         first_pos  = '0;
         latest_pos = '0;
         peaks      = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == CSR_PEAK_BASELINE)
            baseline = val;
         else
            period = val;
      endfunction

      function void push_beat(logic kind, logic [POS_W-1:0] idx, logic [BPM_W-1:0] bpm,
                              logic valid);
         ppr_rsp_type b;
         b.kind       = kind;
         b.peak_index = idx;
         b.bpm_x100   = bpm;
         b.rate_valid = valid;
         b.last       = 1'b0;
         pending.push_back(b);
      endfunction

      // Peak store saturates; later peaks still go out but skip the rate.
      function void close_peak();
         if (int'(peaks) < MAX_PEAKS) begin
            if (peaks == 0)
               first_pos = cand_pos;
            latest_pos = cand_pos;
            peaks      = peaks + 1'b1;
         end
         push_beat(KIND_PEAK, cand_pos, '0, 1'b0);
         cand_open  = 1'b0;
         cand_pos   = '0;
         cand_level = '0;
      endfunction

      function void note_sample(ppr_req_type r);
         int          n0;
         bit          win_end;
         int unsigned span;
         int unsigned interval;
         int unsigned denom;
         logic [BPM_W-1:0] bpm;
         logic        ok;
         ppr_rsp_type tail;
         n0      = pending.size();
         win_end = r.window_end || (int'(pos) >= WINDOW_LEN - 1);
         if (r.sample > baseline) begin
            // equal level moves the candidate to the later position
            if (!cand_open || cand_level <= r.sample) begin
               cand_open  = 1'b1;
               cand_pos   = pos;
               cand_level = r.sample;
            end
         end else if (r.sample < baseline && cand_open) begin
            close_peak();
         end
         if (win_end) begin
            bpm = '0;
            ok  = 1'b0;
            if (cand_open)
               close_peak();
            if (peaks >= 2 && latest_pos >= first_pos) begin
               span     = int'(latest_pos) - int'(first_pos);
               interval = span / (int'(peaks) - 1);
               denom    = interval * int'(period);
               if (denom != 0) begin
                  bpm = BPM_W'(int'(RATE_NUMERATOR) / denom);
                  ok  = 1'b1;
               end
            end
            push_beat(KIND_RATE, '0, bpm, ok);
            clear_window();
         end else begin
            pos = pos + 1'b1;
         end
         if (pending.size() > n0) begin
            tail      = pending.pop_back();
            tail.last = 1'b1;
            pending.push_back(tail);
         end
      endfunction

      function void check_beat(ppr_rsp_type got);
         ppr_rsp_type exp_beat;
         bit          bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected rsp beat: kind=%0d idx=%0d bpm=%0d valid=%0d last=%0d",
                        $time, got.kind, got.peak_index, got.bpm_x100, got.rate_valid,
                        got.last);
            return;
         end
         exp_beat = pending.pop_front();
         bad = (got.kind !== exp_beat.kind) || (got.peak_index !== exp_beat.peak_index) ||
               (got.bpm_x100 !== exp_beat.bpm_x100) ||
               (got.rate_valid !== exp_beat.rate_valid) || (got.last !== exp_beat.last);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] rsp mismatch: kind %0d/%0d idx %0d/%0d bpm %0d/%0d",
                        $time, exp_beat.kind, got.kind, exp_beat.peak_index,
                        got.peak_index, exp_beat.bpm_x100, got.bpm_x100);
               $display("        valid %0d/%0d last %0d/%0d (expected/actual)",
                        exp_beat.rate_valid, got.rate_valid, exp_beat.last, got.last);
            end
         end
      endfunction

      function int close_out();
         if (pending.size() != 0) begin
            $display("%0d expected rsp beats never arrived", pending.size());
            mismatches += pending.size();
         end
         return mismatches;
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   ppr_req_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   ppr_rsp_type          rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   pulse_scoreboard sb;
   bit              tx_burst = 1'b0;   // sender runs with no gaps
   bit              rx_burst = 1'b0;   // receiver never stalls
   int              phase_sent;
   int              idle_cycles = 0;
   int              failures;

   pulse_peak_rate_detector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: any accepted beat on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("** pulse_peak_rate_detector: FAILED **");
            $finish;
         end
      end
   end

   // Both registers back to back; we drops once after the second write.
   task automatic write_config(logic [CFG_W-1:0] level, logic [CFG_W-1:0] ms);
      csr_we    <= 1'b1;
      csr_index <= CSR_PEAK_BASELINE;
      csr_wdata <= level;
      @(posedge clock);
      sb.set_reg(CSR_PEAK_BASELINE, level);
      csr_index <= CSR_SAMPLE_PERIOD_MS;
      csr_wdata <= ms;
      @(posedge clock);
      sb.set_reg(CSR_SAMPLE_PERIOD_MS, ms);
      csr_we <= 1'b0;
   endtask

   // One req beat. Valid only drops when a gap is drawn, so back-to-back
   // beats keep it high across the step.
   task automatic send_sample(ppr_req_type item);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(item);
      phase_sent++;
   endtask

   task automatic send_value(int level, bit win_end);
      ppr_req_type item;
      item.sample     = SAMPLE_BITS'(level);
      item.window_end = win_end;
      send_sample(item);
   endtask

   // Sender holds off until every predicted beat has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   // One window. Shaped windows alternate runs above and below the baseline
   // (with ties and baseline hits) and end at target_len; a target past the
   // window length lets the block end it on overrun. Noisy windows use raw
   // samples and a random window_end. Either way it runs until the window
   // position wraps back to zero.
   task automatic run_window(int target_len, bit noisy);
      ppr_req_type item;
      int          run;
      bit          high;
      int          pick;
      int          prev_high;
      int          lvl;
      tx_burst  = ($urandom_range(0, 3) == 0);
      run       = 0;
      high      = $urandom_range(0, 1);
      prev_high = -1;
      do begin
         if (noisy) begin
            item.sample     = SAMPLE_BITS'($urandom_range(0, 1023));
            item.window_end = ($urandom_range(0, 7) == 0);
         end else begin
            if (run == 0) begin
               high      = !high;
               run       = $urandom_range(1, 4);
               prev_high = -1;
            end
            run--;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               lvl = int'(sb.baseline);
            end else if (high) begin
               if (pick == 1 && prev_high > int'(sb.baseline))
                  lvl = prev_high;  // tie: later position should win
               else if (sb.baseline < 1023)
                  lvl = $urandom_range(1023, int'(sb.baseline) + 1);
               else
                  lvl = 1023;
               prev_high = lvl;
            end else begin
               lvl = (sb.baseline > 0) ? $urandom_range(int'(sb.baseline) - 1, 0) : 0;
            end
            item.sample     = SAMPLE_BITS'(lvl);
            item.window_end = (int'(sb.pos) >= target_len - 1);
         end
         send_sample(item);
      end while (sb.pos != 0);
   endtask

   // Receiver: random stall before each rsp beat, full-rate stretches now and then.
   initial begin
      int stall;
      int beats;
      beats = 0;
      while (reset) @(posedge clock);
      forever begin
         if (beats % 16 == 0)
            rx_burst = ($urandom_range(0, 3) == 0);
         stall = rx_burst ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_beat(rsp_data);
         beats++;
      end
   end

   initial begin
      logic [CFG_W-1:0] level_tab[NUM_PHASES];
      logic [CFG_W-1:0] ms_tab[NUM_PHASES];
      int               kind_draw;
      bit               paused;
      sb = new();

      // Phase settings: reset values, both extremes, zero period, then random.
      level_tab[0] = BASELINE_RESET;  ms_tab[0] = PERIOD_RESET;
      level_tab[1] = '0;              ms_tab[1] = CFG_W'(1);
      level_tab[2] = CFG_W'(1023);    ms_tab[2] = CFG_W'(1000);
      level_tab[3] = CFG_W'(512);     ms_tab[3] = '0;
      level_tab[4] = CFG_W'(1);       ms_tab[4] = CFG_W'(1000);
      level_tab[5] = CFG_W'(1022);    ms_tab[5] = CFG_W'(1);
      level_tab[6] = CFG_W'($urandom_range(0, 1023));
      ms_tab[6]    = CFG_W'($urandom_range(0, 1023));
      level_tab[7] = CFG_W'($urandom_range(100, 400));
      ms_tab[7]    = CFG_W'($urandom_range(1, 1000));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_config(BASELINE_RESET, PERIOD_RESET);

      // Directed: below, equal baseline, ties, a drop that does not close,
      // one-above closes on one-below, window end closing an open peak.
      send_value(0, 0);
      send_value(205, 0);
      send_value(1023, 0);
      send_value(1023, 0);
      send_value(205, 0);
      send_value(300, 0);
      send_value(0, 0);
      send_value(206, 0);
      send_value(204, 0);
      send_value(500, 1);
      // peak at position zero, then too few peaks for a rate
      send_value(1023, 0);
      send_value(0, 1);
      // empty window
      send_value(0, 1);
      // closing sample and window end on the same beat
      send_value(511, 0);
      send_value(0, 0);
      send_value(1023, 0);
      send_value(512, 0);
      send_value(0, 1);
      // single sample window that opens and closes at once
      send_value(1023, 1);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_results();
         repeat (SETTLE) @(posedge clock);
         write_config(level_tab[ph], ms_tab[ph]);
         phase_sent = 0;
         paused     = 1'b0;
         while (phase_sent < PHASE_LEN) begin
            kind_draw = $urandom_range(0, 19);
            if (kind_draw < 2)
               run_window(0, 1'b1);
            else if (kind_draw == 2)
               run_window(WINDOW_LEN + 16, 1'b0);
            else
               run_window($urandom_range(2, 24), 1'b0);
            // hold the sender once mid-phase until the block has drained
            if (!paused && phase_sent >= PHASE_LEN / 2) begin
               drain_results();
               paused = 1'b1;
            end
         end
      end

      drain_results();
      repeat (SETTLE + 36) @(posedge clock);
      failures = sb.close_out();
      if (failures == 0)
         $display("** pulse_peak_rate_detector: PASSED **");
      else
         $display("** pulse_peak_rate_detector: FAILED **");
      $finish;
   end

endmodule
